[rtl/core/tgcw_pkg.sv]
// Shared types, codes and default sizes of the text grid cursor writer.
package tgcw_pkg;

	localparam int unsigned GridColumnsDef = 80;
	localparam int unsigned GridRowsDef    = 25;

	localparam logic [7:0] ByteCr         = 8'd13;
	localparam logic [7:0] ByteLf         = 8'd10;
	localparam logic [7:0] FirstPrintable = 8'd32;
	localparam logic [7:0] LastPrintable  = 8'd127;

	typedef enum logic [1:0] {
		STATUS_STORED = 2'd0,
		STATUS_BREAK  = 2'd1,
		STATUS_REJECT = 2'd2,
		STATUS_READ   = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		OP_STORE  = 2'd0,
		OP_BREAK  = 2'd1,
		OP_REJECT = 2'd2,
		OP_READ   = 2'd3
	} op_kind_t;

	typedef struct packed {
		logic       command;
		logic [7:0] byte_value;
		logic [4:0] read_row;
		logic [6:0] read_column;
	} item_t;

	typedef struct packed {
		status_t    status;
		logic [4:0] cursor_row_out;
		logic [6:0] cursor_column_out;
		logic       scrolled;
		logic [6:0] cell_value;
	} result_t;

	typedef struct packed {
		op_kind_t   kind;
		logic [6:0] char_code;
		logic [4:0] row;
		logic [6:0] column;
		logic       in_range;
	} op_t;

endpackage

[rtl/core/tgcw_stream_if.sv]
// Valid/ready channel carrying one payload per transaction.
interface tgcw_stream_if #(
	parameter type payload_t = logic
) ();
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

[rtl/core/tgcw_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
module tgcw_ram #(
	parameter int unsigned WIDTH = 7,
	parameter int unsigned DEPTH = 2000
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

[rtl/core/tgcw_front.sv]
// Front end: takes stream transactions and classifies them into back-end ops.
module tgcw_front #(
	parameter int unsigned GRID_COLUMNS = tgcw_pkg::GridColumnsDef,
	parameter int unsigned GRID_ROWS    = tgcw_pkg::GridRowsDef
) (
	tgcw_stream_if.sink       item,
	input  logic              accept_en,
	output logic              push_valid,
	output tgcw_pkg::op_t     push_op,
	input  logic              push_ready
);
	tgcw_pkg::item_t in_q;

	assign in_q       = item.payload;
	assign item.ready = push_ready && accept_en;
	assign push_valid = item.valid && accept_en;

	always_comb begin
		push_op           = '0;
		push_op.char_code = in_q.byte_value[6:0];
		push_op.row       = in_q.read_row;
		push_op.column    = in_q.read_column;
		push_op.in_range  = (int'(in_q.read_row) < GRID_ROWS) &&
			(int'(in_q.read_column) < GRID_COLUMNS);
		priority if (in_q.command) begin
			push_op.kind = tgcw_pkg::OP_READ;
		end else if (in_q.byte_value == tgcw_pkg::ByteCr ||
			in_q.byte_value == tgcw_pkg::ByteLf) begin
			push_op.kind = tgcw_pkg::OP_BREAK;
		end else if (in_q.byte_value < tgcw_pkg::FirstPrintable ||
			in_q.byte_value > tgcw_pkg::LastPrintable) begin
			push_op.kind = tgcw_pkg::OP_REJECT;
		end else begin
			push_op.kind = tgcw_pkg::OP_STORE;
		end
	end
endmodule

[rtl/core/tgcw_queue.sv]
// Two-entry op queue between front end and back end.
module tgcw_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push_valid,
	input  tgcw_pkg::op_t push_op,
	output logic          push_ready,
	output logic          pop_valid,
	output tgcw_pkg::op_t pop_op,
	input  logic          pop_ready
);
	tgcw_pkg::op_t entry_q [2];
	logic          wr_ptr_q;
	logic          rd_ptr_q;
	logic [1:0]    count_q;
	logic          push;
	logic          pop;

	assign push_ready = (count_q != 2'd2);
	assign pop_valid  = (count_q != 2'd0);
	assign pop_op     = entry_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_op;
		end
	end
endmodule

[rtl/core/tgcw_back.sv]
// Back end: cursor, circular row store with row clearing, and result register.
module tgcw_back #(
	parameter int unsigned GRID_COLUMNS = tgcw_pkg::GridColumnsDef,
	parameter int unsigned GRID_ROWS    = tgcw_pkg::GridRowsDef
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              pop_valid,
	input  tgcw_pkg::op_t     pop_op,
	output logic              pop_ready,
	output logic              accept_en,
	tgcw_stream_if.source     result
);
	localparam int unsigned Depth = GRID_ROWS * GRID_COLUMNS;
	localparam int unsigned AW    = $clog2(Depth);
	localparam int unsigned RW    = $clog2(GRID_ROWS);
	localparam int unsigned CW    = $clog2(GRID_COLUMNS);

	localparam logic [AW-1:0] LastAddr = AW'(Depth - 1);
	localparam logic [AW-1:0] ColsA    = AW'(GRID_COLUMNS);
	localparam logic [AW-1:0] ColsM1A  = AW'(GRID_COLUMNS - 1);
	localparam logic [CW-1:0] LastCol  = CW'(GRID_COLUMNS - 1);
	localparam logic [RW-1:0] LastRow  = RW'(GRID_ROWS - 1);
	localparam logic [RW:0]   RowsW    = (RW + 1)'(GRID_ROWS);

	typedef enum logic [3:0] {
		S_INIT  = 4'b0001,
		S_IDLE  = 4'b0010,
		S_READ  = 4'b0100,
		S_CLEAR = 4'b1000
	} state_t;

	state_t            state_q;
	logic [RW-1:0]     cur_row_q;
	logic [CW-1:0]     cur_col_q;
	logic [RW-1:0]     top_q;
	logic [AW-1:0]     clr_addr_q;
	logic [AW-1:0]     clr_last_q;
	logic              rd_in_range_q;
	logic              res_valid_q;
	tgcw_pkg::result_t res_q;

	logic              start;
	logic              clearing;
	logic              is_read;
	logic [RW-1:0]     acc_row;
	logic [CW-1:0]     acc_col;
	logic [RW:0]       phys_sum;
	logic [RW:0]       phys_row;
	logic [AW-1:0]     acc_addr;
	logic [AW-1:0]     top_base;
	logic              wraps;
	logic              at_bottom;
	logic              scroll;
	logic [RW-1:0]     row_n;
	logic [CW-1:0]     col_n;
	logic [RW-1:0]     top_n;
	logic              res_load;
	tgcw_pkg::result_t res_next;
	logic              ram_we;
	logic [AW-1:0]     ram_waddr;
	logic [6:0]        ram_wdata;
	logic [6:0]        ram_rdata;

	assign accept_en    = (state_q != S_INIT);
	assign clearing     = (state_q == S_INIT) || (state_q == S_CLEAR);
	assign start        = (state_q == S_IDLE) && pop_valid && (!res_valid_q || result.ready);
	assign pop_ready    = start;
	assign is_read      = (pop_op.kind == tgcw_pkg::OP_READ);

	assign acc_row  = is_read ? RW'(pop_op.row) : cur_row_q;
	assign acc_col  = is_read ? CW'(pop_op.column) : cur_col_q;
	assign phys_sum = {1'b0, top_q} + (RW + 1)'(acc_row);
	assign phys_row = (phys_sum >= RowsW) ? (phys_sum - RowsW) : phys_sum;
	assign acc_addr = AW'(phys_row) * ColsA + AW'(acc_col);
	assign top_base = AW'(top_q) * ColsA;

	assign at_bottom = (cur_row_q == LastRow);
	assign wraps     = (pop_op.kind == tgcw_pkg::OP_BREAK) ||
		((pop_op.kind == tgcw_pkg::OP_STORE) && (cur_col_q == LastCol));
	assign scroll    = wraps && at_bottom;
	assign top_n     = (top_q == LastRow) ? '0 : top_q + RW'(1);

	always_comb begin
		row_n = cur_row_q;
		col_n = cur_col_q;
		if (wraps) begin
			col_n = '0;
			if (!at_bottom) begin
				row_n = cur_row_q + RW'(1);
			end
		end else if (pop_op.kind == tgcw_pkg::OP_STORE) begin
			col_n = cur_col_q + CW'(1);
		end
	end

	always_comb begin
		res_load = 1'b0;
		res_next = '0;
		if (state_q == S_READ) begin
			res_load                   = 1'b1;
			res_next.status            = tgcw_pkg::STATUS_READ;
			res_next.cursor_row_out    = 5'(cur_row_q);
			res_next.cursor_column_out = 7'(cur_col_q);
			res_next.cell_value        = rd_in_range_q ? ram_rdata : 7'd0;
		end else if (start && !is_read) begin
			res_load                   = 1'b1;
			res_next.cursor_row_out    = 5'(row_n);
			res_next.cursor_column_out = 7'(col_n);
			res_next.scrolled          = scroll;
			unique case (pop_op.kind)
				tgcw_pkg::OP_STORE:  res_next.status = tgcw_pkg::STATUS_STORED;
				tgcw_pkg::OP_BREAK:  res_next.status = tgcw_pkg::STATUS_BREAK;
				default:             res_next.status = tgcw_pkg::STATUS_REJECT;
			endcase
		end
	end

	assign ram_we    = clearing || (start && (pop_op.kind == tgcw_pkg::OP_STORE));
	assign ram_waddr = clearing ? clr_addr_q : acc_addr;
	assign ram_wdata = clearing ? 7'd0 : pop_op.char_code;

	tgcw_ram #(
		.WIDTH(7),
		.DEPTH(Depth)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(acc_addr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_INIT;
			cur_row_q     <= '0;
			cur_col_q     <= '0;
			top_q         <= '0;
			clr_addr_q    <= '0;
			clr_last_q    <= LastAddr;
			rd_in_range_q <= 1'b0;
			res_valid_q   <= 1'b0;
		end else begin
			if (res_load) begin
				res_valid_q <= 1'b1;
			end else if (result.ready) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_INIT, S_CLEAR: begin
					if (clr_addr_q == clr_last_q) begin
						state_q <= S_IDLE;
					end else begin
						clr_addr_q <= clr_addr_q + AW'(1);
					end
				end
				S_IDLE: begin
					if (start) begin
						if (is_read) begin
							rd_in_range_q <= pop_op.in_range;
							state_q       <= S_READ;
						end else begin
							cur_row_q <= row_n;
							cur_col_q <= col_n;
							if (scroll) begin
								top_q      <= top_n;
								clr_addr_q <= top_base;
								clr_last_q <= top_base + ColsM1A;
								state_q    <= S_CLEAR;
							end
						end
					end
				end
				S_READ: begin
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_INIT;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			res_q <= res_next;
		end
	end

	assign result.valid   = res_valid_q;
	assign result.payload = res_q;
endmodule

[rtl/core/text_grid_cursor_writer_core.sv]
// Top level of the text grid cursor writer: front end, op queue and back end.
// Character grid of GRID_ROWS x GRID_COLUMNS 7-bit cells fed by a terminal byte stream.
// After reset the cell RAM is swept to zero one cell per cycle, all GRID_ROWS*GRID_COLUMNS
// cells (2000 by default), and no transaction is accepted until the sweep ends.
// A put (store, line break, rejected byte) is done in the idle state; a cell read also
// passes the read state as the RAM read data is registered. Rows are kept in a circular
// order, so a scroll only advances the top-row pointer and then clears the freed row,
// one cell per cycle, all GRID_COLUMNS cells (80 by default) before the next op starts.
// A two-entry queue lets the input side keep taking transactions while the back end works
// or the result register waits; each transaction yields exactly one result.
module text_grid_cursor_writer_core #(
	parameter int unsigned GRID_COLUMNS = tgcw_pkg::GridColumnsDef,
	parameter int unsigned GRID_ROWS    = tgcw_pkg::GridRowsDef
) (
	input  logic          clk,
	input  logic          arst_n,
	tgcw_stream_if.sink   item,
	tgcw_stream_if.source result
);
	logic          accept_en;
	logic          push_valid;
	tgcw_pkg::op_t push_op;
	logic          push_ready;
	logic          pop_valid;
	tgcw_pkg::op_t pop_op;
	logic          pop_ready;

	tgcw_front #(
		.GRID_COLUMNS(GRID_COLUMNS),
		.GRID_ROWS   (GRID_ROWS)
	) u_front (
		.item      (item),
		.accept_en (accept_en),
		.push_valid(push_valid),
		.push_op   (push_op),
		.push_ready(push_ready)
	);

	tgcw_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_valid(push_valid),
		.push_op   (push_op),
		.push_ready(push_ready),
		.pop_valid (pop_valid),
		.pop_op    (pop_op),
		.pop_ready (pop_ready)
	);

	tgcw_back #(
		.GRID_COLUMNS(GRID_COLUMNS),
		.GRID_ROWS   (GRID_ROWS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.pop_valid(pop_valid),
		.pop_op   (pop_op),
		.pop_ready(pop_ready),
		.accept_en(accept_en),
		.result   (result)
	);
endmodule
